// ===== hdl/shkt_pkg.sv =====
package shkt_pkg;

    localparam int DEPTH  = 1024;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int IDX_W  = CNT_W + 1;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_SORT   = 2'd1;
    localparam logic [1:0] OP_LOOKUP = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_MISS  = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    typedef struct packed {
        logic [63:0] key_high;
        logic [63:0] key_low;
        logic [63:0] value;
    } entry_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SORT_RD,
        S_SORT_CMP,
        S_COPY_RD,
        S_COPY_WR,
        S_LOOK_RD,
        S_LOOK_CMP,
        S_RESP
    } state_t;

    typedef struct packed {
        logic [ADDR_W-1:0] raddr_a;
        logic [ADDR_W-1:0] raddr_b;
        logic              we;
        logic [ADDR_W-1:0] waddr;
        entry_t            wdata;
        logic [ADDR_W-1:0] scr_raddr;
        logic              scr_we;
        logic [ADDR_W-1:0] scr_waddr;
        entry_t            scr_wdata;
    } mem_req_t;

endpackage

// ===== hdl/shkt_store.sv =====
module shkt_store
    import shkt_pkg::*;
(
    input  logic     aclk,
    input  mem_req_t req,
    output entry_t   rdata_a,
    output entry_t   rdata_b,
    output entry_t   scr_rdata
);

    entry_t main_mem [DEPTH];
    entry_t scr_mem  [DEPTH];

    always_ff @(posedge aclk) begin
        if (req.we) begin
            main_mem[req.waddr] <= req.wdata;
        end
        rdata_a <= main_mem[req.raddr_a];
        rdata_b <= main_mem[req.raddr_b];
    end

    always_ff @(posedge aclk) begin
        if (req.scr_we) begin
            scr_mem[req.scr_waddr] <= req.scr_wdata;
        end
        scr_rdata <= scr_mem[req.scr_raddr];
    end

endmodule

// ===== hdl/sorted_hash_key_table_top.sv =====
// Flow: add and clear go through S_RESP to the result register; lookup makes one
// read and compare per binary-search probe; sort reads and compares per element
// merged and per pair of runs, then copies every element back; log2(entries) passes.
// Throughput: one request at a time, set by the single read-compare loop on the store.
// Reset: synchronous, active low; clears the count and handshake state, stores undefined.
module sorted_hash_key_table_top
    import shkt_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [191:0] s_tdata,   // key_high, key_low, entry_value
    input  logic [1:0]   s_tuser,   // opcode
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [79:0]  m_tdata,   // found_value, entry_count, zero pad
    output logic [1:0]   m_tuser    // status
);

    state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [63:0] kh_reg, kh_next, kl_reg, kl_next;
    logic [IDX_W-1:0] w_reg, w_next, lo_reg, lo_next, mid_reg, mid_next;
    logic [IDX_W-1:0] hi_reg, hi_next, a_reg, a_next, b_reg, b_next, k_reg, k_next;
    logic [IDX_W-1:0] low_reg, low_next, high_reg, high_next;
    logic [1:0]  res_status_reg, res_status_next;
    logic [63:0] res_value_reg, res_value_next;
    logic        m_tvalid_reg, m_tvalid_next;
    logic [79:0] m_tdata_reg, m_tdata_next;
    logic [1:0]  m_tuser_reg, m_tuser_next;

    mem_req_t req;
    entry_t   rdata_a, rdata_b, scr_rdata;

    logic [IDX_W-1:0] n_idx, probe, lo_adv, w_dbl, seg_mid, seg_hi;
    logic             a_ok, b_ok, take_a, accept;
    logic [127:0]     key_a, key_b, key_q;

    shkt_store u_store (
        .aclk      (aclk),
        .req       (req),
        .rdata_a   (rdata_a),
        .rdata_b   (rdata_b),
        .scr_rdata (scr_rdata)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    assign n_idx  = {1'b0, count_reg};
    assign probe  = low_reg + ((high_reg - low_reg) >> 1);
    assign key_a  = {rdata_a.key_high, rdata_a.key_low};
    assign key_b  = {rdata_b.key_high, rdata_b.key_low};
    assign key_q  = {kh_reg, kl_reg};
    assign a_ok   = a_reg < mid_reg;
    assign b_ok   = b_reg < hi_reg;
    assign take_a = a_ok && (!b_ok || (key_a <= key_b));

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        kh_next         = kh_reg;
        kl_next         = kl_reg;
        w_next          = w_reg;
        lo_next         = lo_reg;
        mid_next        = mid_reg;
        hi_next         = hi_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        k_next          = k_reg;
        low_next        = low_reg;
        high_next       = high_reg;
        res_status_next = res_status_reg;
        res_value_next  = res_value_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;
        lo_adv          = '0;
        w_dbl           = '0;
        seg_mid         = '0;
        seg_hi          = '0;

        req.raddr_a   = ((state_reg == S_SORT_RD) || (state_reg == S_SORT_CMP))
                        ? a_reg[ADDR_W-1:0] : probe[ADDR_W-1:0];
        req.raddr_b   = b_reg[ADDR_W-1:0];
        req.we        = 1'b0;
        req.waddr     = k_reg[ADDR_W-1:0];
        req.wdata     = scr_rdata;
        req.scr_raddr = k_reg[ADDR_W-1:0];
        req.scr_we    = 1'b0;
        req.scr_waddr = k_reg[ADDR_W-1:0];
        req.scr_wdata = take_a ? rdata_a : rdata_b;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    kh_next         = s_tdata[63:0];
                    kl_next         = s_tdata[127:64];
                    res_status_next = ST_OK;
                    res_value_next  = '1;
                    state_next      = S_RESP;
                    unique case (s_tuser)
                        OP_ADD: begin
                            if (n_idx >= IDX_W'(DEPTH)) begin
                                res_status_next = ST_FULL;
                            end else begin
                                req.we     = 1'b1;
                                req.waddr  = count_reg[ADDR_W-1:0];
                                req.wdata  = '{key_high: s_tdata[63:0],
                                               key_low:  s_tdata[127:64],
                                               value:    s_tdata[191:128]};
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        OP_SORT: begin
                            if (n_idx > IDX_W'(1)) begin
                                // first pass: runs of one
                                w_next     = IDX_W'(1);
                                lo_next    = '0;
                                a_next     = '0;
                                k_next     = '0;
                                mid_next   = IDX_W'(1);
                                b_next     = IDX_W'(1);
                                hi_next    = IDX_W'(2);
                                state_next = S_SORT_RD;
                            end
                        end
                        OP_LOOKUP: begin
                            if (count_reg == '0) begin
                                res_status_next = ST_EMPTY;
                            end else begin
                                low_next   = '0;
                                high_next  = n_idx - IDX_W'(1);
                                state_next = S_LOOK_RD;
                            end
                        end
                        OP_CLEAR: begin
                            count_next = '0;
                        end
                        default: ;
                    endcase
                end
            end
            S_SORT_RD: begin
                state_next = S_SORT_CMP;
            end
            S_SORT_CMP: begin
                if (a_ok || b_ok) begin
                    req.scr_we = 1'b1;
                    k_next     = k_reg + IDX_W'(1);
                    if (take_a) begin
                        a_next = a_reg + IDX_W'(1);
                    end else begin
                        b_next = b_reg + IDX_W'(1);
                    end
                    state_next = S_SORT_RD;
                end else begin
                    // advance to the next pair of runs
                    lo_adv  = lo_reg + (w_reg << 1);
                    seg_mid = (lo_adv + w_reg < n_idx) ? lo_adv + w_reg : n_idx;
                    seg_hi  = (seg_mid + w_reg < n_idx) ? seg_mid + w_reg : n_idx;
                    if (lo_adv < n_idx) begin
                        lo_next    = lo_adv;
                        a_next     = lo_adv;
                        mid_next   = seg_mid;
                        b_next     = seg_mid;
                        hi_next    = seg_hi;
                        state_next = S_SORT_RD;
                    end else begin
                        k_next     = '0;
                        state_next = S_COPY_RD;
                    end
                end
            end
            S_COPY_RD: begin
                state_next = S_COPY_WR;
            end
            S_COPY_WR: begin
                req.we = 1'b1;
                k_next = k_reg + IDX_W'(1);
                if (k_reg + IDX_W'(1) >= n_idx) begin
                    w_dbl = w_reg << 1;
                    if (w_dbl >= n_idx) begin
                        state_next = S_RESP;
                    end else begin
                        seg_hi     = (w_dbl + w_dbl < n_idx) ? w_dbl + w_dbl : n_idx;
                        w_next     = w_dbl;
                        lo_next    = '0;
                        a_next     = '0;
                        k_next     = '0;
                        mid_next   = w_dbl;
                        b_next     = w_dbl;
                        hi_next    = seg_hi;
                        state_next = S_SORT_RD;
                    end
                end else begin
                    state_next = S_COPY_RD;
                end
            end
            S_LOOK_RD: begin
                state_next = S_LOOK_CMP;
            end
            S_LOOK_CMP: begin
                state_next      = S_RESP;
                res_status_next = ST_MISS;
                if (probe < n_idx) begin
                    if (key_q == key_a) begin
                        res_status_next = ST_OK;
                        res_value_next  = rdata_a.value;
                    end else if (key_q < key_a) begin
                        if (probe != '0 && low_reg <= probe - IDX_W'(1)) begin
                            high_next  = probe - IDX_W'(1);
                            state_next = S_LOOK_RD;
                        end
                    end else if (probe + IDX_W'(1) <= high_reg) begin
                        low_next   = probe + IDX_W'(1);
                        state_next = S_LOOK_RD;
                    end
                end
            end
            S_RESP: begin
                // hold until the result register is free
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = res_status_reg;
                    m_tdata_next  = {5'd0, count_reg, res_value_reg};
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        kh_reg         <= kh_next;
        kl_reg         <= kl_next;
        w_reg          <= w_next;
        lo_reg         <= lo_next;
        mid_reg        <= mid_next;
        hi_reg         <= hi_next;
        a_reg          <= a_next;
        b_reg          <= b_next;
        k_reg          <= k_next;
        low_reg        <= low_next;
        high_reg       <= high_next;
        res_status_reg <= res_status_next;
        res_value_reg  <= res_value_next;
        m_tdata_reg    <= m_tdata_next;
        m_tuser_reg    <= m_tuser_next;
    end

endmodule

// ===== hdl/shkt_checker.sv =====
module shkt_checker
    import shkt_pkg::*;
(
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [191:0] s_tdata,
    input logic [1:0]   s_tuser,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [79:0]  m_tdata,
    input logic [1:0]   m_tuser
);

    logic unused_in;
    assign unused_in = s_tvalid ^ s_tready ^ (^s_tdata) ^ (^s_tuser);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == ST_FULL |-> m_tdata[74:64] == CNT_W'(DEPTH))
        else $error("full reported below capacity");

    a_empty_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == ST_EMPTY |-> m_tdata[74:64] == '0)
        else $error("empty reported with entries");

    a_no_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != ST_OK |-> m_tdata[63:0] == '1)
        else $error("value given on failed request");

endmodule

bind sorted_hash_key_table_top shkt_checker u_shkt_checker (.*);

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import shkt_pkg::*;

    typedef struct {
        logic [1:0]  op;
        logic [63:0] kh;
        logic [63:0] kl;
        logic [63:0] val;
        bit          pause;
    } request_t;

    typedef struct {
        logic [1:0]       status;
        logic [63:0]      value;
        logic [CNT_W-1:0] count;
    } reply_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [191:0] s_tdata = '0;
    logic [1:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [79:0]  m_tdata;
    logic [1:0]   m_tuser;

    request_t pending_reqs[$];
    reply_t   expected_replies[$];
    request_t cur_req;
    int       errors = 0;
    int       accepted = 0;
    int       send_gap = 0;
    int       recv_gap = 0;
    bit       long_hold_done = 1'b0;
    bit       stim_done = 1'b0;

    // shadow copy of the table
    logic [63:0] tab_kh[DEPTH];
    logic [63:0] tab_kl[DEPTH];
    logic [63:0] tab_v[DEPTH];
    logic [63:0] scr_kh[DEPTH];
    logic [63:0] scr_kl[DEPTH];
    logic [63:0] scr_v[DEPTH];
    int          tab_count = 0;

    sorted_hash_key_table_top u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always #10 aclk = ~aclk;

    // -1, 0, +1 as key a is below, equal to or above key b
    function automatic int key_order(logic [63:0] ah, logic [63:0] al,
                                     logic [63:0] bh, logic [63:0] bl);
        if (ah != bh) return (ah < bh) ? -1 : 1;
        if (al != bl) return (al < bl) ? -1 : 1;
        return 0;
    endfunction

    task automatic merge_runs(int lo, int mid, int hi);
        int a;
        int b;
        int k;
        a = lo;
        b = mid;
        k = lo;
        while (k < hi) begin
            if (b >= hi || (a < mid &&
                    key_order(tab_kh[a], tab_kl[a], tab_kh[b], tab_kl[b]) <= 0)) begin
                scr_kh[k] = tab_kh[a]; scr_kl[k] = tab_kl[a]; scr_v[k] = tab_v[a];
                a++;
            end else begin
                scr_kh[k] = tab_kh[b]; scr_kl[k] = tab_kl[b]; scr_v[k] = tab_v[b];
                b++;
            end
            k++;
        end
        for (k = lo; k < hi; k++) begin
            tab_kh[k] = scr_kh[k]; tab_kl[k] = scr_kl[k]; tab_v[k] = scr_v[k];
        end
    endtask

    task automatic sort_shadow();
        int w;
        int lo;
        int mid;
        for (w = 1; w < tab_count; w *= 2) begin
            for (lo = 0; lo + w < tab_count; lo += 2 * w) begin
                mid = lo + w;
                merge_runs(lo, mid, (tab_count - mid > w) ? mid + w : tab_count);
            end
        end
    endtask

    task automatic predict_reply(request_t rq);
        reply_t r;
        int lo;
        int hi;
        int mid;
        int c;
        bit hit;
        r.status = ST_OK;
        r.value = '1;
        case (rq.op)
            OP_ADD: begin
                if (tab_count >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    tab_kh[tab_count] = rq.kh;
                    tab_kl[tab_count] = rq.kl;
                    tab_v[tab_count] = rq.val;
                    tab_count++;
                end
            end
            OP_SORT: sort_shadow();
            OP_LOOKUP: begin
                if (tab_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    hit = 1'b0;
                    lo = 0;
                    hi = tab_count - 1;
                    while (lo <= hi && !hit) begin
                        mid = lo + (hi - lo) / 2;
                        c = key_order(rq.kh, rq.kl, tab_kh[mid], tab_kl[mid]);
                        if (c == 0) begin
                            hit = 1'b1;
                            r.value = tab_v[mid];
                        end else if (c < 0) begin
                            hi = mid - 1;
                        end else begin
                            lo = mid + 1;
                        end
                    end
                    if (!hit) r.status = ST_MISS;
                end
            end
            default: tab_count = 0;
        endcase
        r.count = tab_count[CNT_W-1:0];
        expected_replies.push_back(r);
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_reply(cur_req);
                accepted++;
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_reqs.size() == 0) begin
                    s_tvalid <= 1'b0;
                end else if (pending_reqs[0].pause) begin
                    // hold until every reply has drained
                    if (expected_replies.size() == 0) void'(pending_reqs.pop_front());
                    s_tvalid <= 1'b0;
                end else if (pending_reqs.size() > 150 && $urandom_range(0, 11) == 0) begin
                    send_gap = $urandom_range(1, 15);
                    s_tvalid <= 1'b0;
                end else begin
                    cur_req = pending_reqs.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {cur_req.val, cur_req.kl, cur_req.kh};
                    s_tuser <= cur_req.op;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        reply_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_replies.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("unexpected reply: status %0d value %h count %0d",
                                               m_tuser, m_tdata[63:0], m_tdata[74:64]);
                end else begin
                    want = expected_replies.pop_front();
                    if (m_tuser !== want.status || m_tdata[63:0] !== want.value ||
                            m_tdata[74:64] !== want.count) begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: exp status %0d value %h count %0d, got %0d %h %0d",
                                     want.status, want.value, want.count,
                                     m_tuser, m_tdata[63:0], m_tdata[74:64]);
                    end
                end
            end
            if (!long_hold_done && accepted >= 1200) begin
                // long hold-off to back up the input side
                long_hold_done = 1'b1;
                recv_gap = 400;
                m_tready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                m_tready <= 1'b0;
            end else if (pending_reqs.size() > 150 && $urandom_range(0, 9) == 0) begin
                recv_gap = $urandom_range(1, 15);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // stimulus
    logic [63:0] gen_kh[$];
    logic [63:0] gen_kl[$];

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic push_req(logic [1:0] op, logic [63:0] kh, logic [63:0] kl,
                            logic [63:0] val);
        request_t rq;
        rq.op = op; rq.kh = kh; rq.kl = kl; rq.val = val; rq.pause = 1'b0;
        pending_reqs.push_back(rq);
        if (op == OP_ADD) begin
            gen_kh.push_back(kh);
            gen_kl.push_back(kl);
        end else if (op == OP_CLEAR) begin
            gen_kh.delete();
            gen_kl.delete();
        end
    endtask

    task automatic push_pause();
        request_t rq;
        rq = '{op: OP_CLEAR, kh: '0, kl: '0, val: '0, pause: 1'b1};
        pending_reqs.push_back(rq);
    endtask

    function automatic logic [63:0] pick_word();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return 64'(($urandom_range(0, 3)));
            default: return rand64();
        endcase
    endfunction

    task automatic add_random_keys(int n);
        int i;
        int j;
        for (i = 0; i < n; i++) begin
            if (gen_kh.size() > 0 && $urandom_range(0, 4) == 0) begin
                j = $urandom_range(0, gen_kh.size() - 1);
                push_req(OP_ADD, gen_kh[j], ($urandom_range(0, 1)) ? gen_kl[j] : pick_word(),
                         rand64());
            end else begin
                push_req(OP_ADD, pick_word(), pick_word(), rand64());
            end
        end
    endtask

    task automatic lookup_random(int n);
        int i;
        int j;
        for (i = 0; i < n; i++) begin
            if (gen_kh.size() > 0 && $urandom_range(0, 3) != 0) begin
                j = $urandom_range(0, gen_kh.size() - 1);
                push_req(OP_LOOKUP, gen_kh[j], gen_kl[j], rand64());
            end else begin
                push_req(OP_LOOKUP, pick_word(), pick_word(), rand64());
            end
        end
    endtask

    initial begin
        int i;
        int n;
        bit pause_sent;

        pause_sent = 1'b0;

        // directed part
        push_req(OP_LOOKUP, '0, '0, '0);
        push_req(OP_SORT, '1, '1, '1);
        push_req(OP_ADD, '1, '1, 64'h7FFF_FFFF_FFFF_FFFF);
        push_req(OP_SORT, '0, '0, '0);
        push_req(OP_LOOKUP, '1, '1, '0);
        push_req(OP_ADD, '0, '0, 64'h8000_0000_0000_0000);
        push_req(OP_ADD, 64'd5, '1, 64'd1);
        push_req(OP_ADD, 64'd5, '0, 64'd2);
        push_req(OP_ADD, 64'd5, '1, 64'd3);
        push_req(OP_LOOKUP, '0, '0, '0);
        push_req(OP_LOOKUP, 64'd5, '0, '0);
        push_req(OP_SORT, '0, '0, '0);
        push_req(OP_LOOKUP, '0, '0, '0);
        push_req(OP_LOOKUP, 64'd5, '0, '0);
        push_req(OP_LOOKUP, 64'd5, '1, '0);
        push_req(OP_LOOKUP, '1, '1, '0);
        push_req(OP_LOOKUP, 64'd6, '0, '0);
        push_req(OP_CLEAR, '1, '1, '1);
        push_req(OP_LOOKUP, 64'd5, '0, '0);

        // fill to capacity, overflow, sort and search the full table
        for (i = 0; i < DEPTH; i++) push_req(OP_ADD, rand64(), rand64(), rand64());
        push_req(OP_ADD, '1, '0, '0);
        push_req(OP_ADD, '0, '1, '1);
        push_req(OP_SORT, '0, '0, '0);
        lookup_random(6);
        push_req(OP_CLEAR, '0, '0, '0);

        // random sequences
        n = 0;
        while (n < 350) begin
            if (!pause_sent && n > 150) begin
                push_pause();
                pause_sent = 1'b1;
            end
            i = pending_reqs.size();
            if ($urandom_range(0, 9) == 0) begin
                push_req(2'($urandom_range(0, 3)), rand64(), rand64(), rand64());
            end else begin
                if ($urandom_range(0, 2) == 0 || gen_kh.size() > 40) push_req(OP_CLEAR, rand64(), rand64(), rand64());
                add_random_keys($urandom_range(1, 24));
                if ($urandom_range(0, 3) == 0) lookup_random($urandom_range(1, 3));
                push_req(OP_SORT, rand64(), rand64(), rand64());
                lookup_random($urandom_range(2, 10));
            end
            n += pending_reqs.size() - i;
        end
        stim_done = 1'b1;
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        wait (stim_done && pending_reqs.size() == 0 && !s_tvalid &&
              expected_replies.size() == 0);
        repeat (100) @(posedge aclk);
        if (errors == 0 && expected_replies.size() == 0) begin
            $display("** sorted_hash_key_table_top: PASSED **");
        end else begin
            $display("** sorted_hash_key_table_top: FAILED **");
        end
        $finish;
    end

    initial begin
        #60_000_000;
        $display("** sorted_hash_key_table_top: FAILED **");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/shkt_pkg.sv
hdl/shkt_store.sv
hdl/sorted_hash_key_table_top.sv
hdl/shkt_checker.sv
tb/testbench.sv
